>>> design/assert_macros.svh
// Assertion macros shared by the parser's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge while out of reset.
`define CHK_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define CHK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> design/tpfp_pkg.sv
// Types and constants shared by the two-plate timer frame parser.
package tpfp_pkg;

  localparam logic [7:0] MARKER_BYTE = 8'h80;
  localparam logic [4:0] POS_MAX     = 5'd31;
  localparam logic [2:0] CHANNELS_RESET = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_BLOCK  = 2'd0;
  localparam logic [1:0] KIND_CHANGE = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Plate numbers as reported on change events
  localparam logic [1:0] PLATE_NONE   = 2'd0;
  localparam logic [1:0] PLATE_FIRST  = 2'd1;
  localparam logic [1:0] PLATE_SECOND = 2'd2;

  // One classified event handed from the front part to the back part
  typedef struct packed {
    logic             is_err;
    logic [31:0]      block_number;
    logic [1:0]       busy_old;
    logic [1:0][31:0] count;
    logic [1:0][23:0] scale;
    logic [1:0]       changed;
    logic [1:0]       busy_new;
    logic [1:0][23:0] time_scale;
  } event_t;

endpackage

>>> design/tpfp_front.sv
// Front part: marker tracking, packet assembly and event classification.
module tpfp_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_wdata,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  output logic             ev_push,
  output tpfp_pkg::event_t ev_data
);

  logic             marker_seen_r, marker_seen_nxt;
  logic             in_packet_r, in_packet_nxt;
  logic [4:0]       pos_r, pos_nxt;
  logic [2:0][7:0]  partial_r, partial_nxt;
  logic [1:0][23:0] scale_r, scale_nxt;
  logic [1:0]       flag_r, flag_nxt;
  logic [1:0][31:0] counter_r, counter_nxt;
  logic [1:0][23:0] tscale_r, tscale_nxt;
  logic [1:0]       busy_r, busy_nxt;
  logic [31:0]      packet_count_r, packet_count_nxt;
  logic [2:0]       channels_r;

  logic       is_marker;
  logic       two;
  logic       err;
  logic       complete;
  logic [4:0] pos_inc;
  logic       plate;

  assign is_marker = (data_byte == tpfp_pkg::MARKER_BYTE);
  assign two       = is_marker && marker_seen_r;
  assign err       = two && in_packet_r;
  assign pos_inc   = (pos_r < tpfp_pkg::POS_MAX) ? pos_r + 5'd1 : pos_r;
  assign plate     = pos_r[3];

  // Classify the byte and compute the next parser state
  always_comb begin
    marker_seen_nxt  = marker_seen_r;
    in_packet_nxt    = in_packet_r;
    pos_nxt          = pos_r;
    partial_nxt      = partial_r;
    scale_nxt        = scale_r;
    flag_nxt         = flag_r;
    counter_nxt      = counter_r;
    tscale_nxt       = tscale_r;
    busy_nxt         = busy_r;
    packet_count_nxt = packet_count_r;
    complete         = 1'b0;
    if (accept) begin
      marker_seen_nxt = is_marker && !marker_seen_r;
      if (two) begin
        in_packet_nxt = 1'b1;
        pos_nxt       = 5'd0;
      end else if (in_packet_r) begin
        // absorb the byte; channels beyond the fourth have no effect
        if (!pos_r[4]) begin
          if (pos_r[1:0] != 2'd3) begin
            partial_nxt[pos_r[1:0]] = data_byte;
          end else if (!pos_r[2]) begin
            scale_nxt[plate] = {partial_r[2], partial_r[1], partial_r[0]};
            flag_nxt[plate]  = (data_byte != 8'd0);
          end else begin
            counter_nxt[plate] = {data_byte, partial_r[2], partial_r[1], partial_r[0]};
            tscale_nxt[plate]  = scale_r[plate];
          end
        end
        pos_nxt = pos_inc;
        if (pos_inc == {channels_r, 2'b00}) begin
          complete         = 1'b1;
          packet_count_nxt = packet_count_r + 32'd1;
          busy_nxt         = flag_nxt;
          in_packet_nxt    = 1'b0;
        end
      end
    end
  end

  // Build the event for the back part
  always_comb begin
    ev_push               = accept && (err || complete);
    ev_data.is_err        = err;
    ev_data.block_number  = packet_count_nxt;
    ev_data.busy_old      = busy_r;
    ev_data.count         = counter_nxt;
    ev_data.scale         = scale_nxt;
    ev_data.changed       = busy_r ^ flag_nxt;
    ev_data.busy_new      = flag_nxt;
    ev_data.time_scale    = tscale_nxt;
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_seen_r  <= 1'b0;
      in_packet_r    <= 1'b0;
      pos_r          <= 5'd0;
      partial_r      <= '0;
      scale_r        <= '0;
      flag_r         <= '0;
      counter_r      <= '0;
      tscale_r       <= '0;
      busy_r         <= '0;
      packet_count_r <= 32'd0;
    end else begin
      marker_seen_r  <= marker_seen_nxt;
      in_packet_r    <= in_packet_nxt;
      pos_r          <= pos_nxt;
      partial_r      <= partial_nxt;
      scale_r        <= scale_nxt;
      flag_r         <= flag_nxt;
      counter_r      <= counter_nxt;
      tscale_r       <= tscale_nxt;
      busy_r         <= busy_nxt;
      packet_count_r <= packet_count_nxt;
    end
  end

  // Hold the channel count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channels_r <= tpfp_pkg::CHANNELS_RESET;
    end else if (cfg_we) begin
      channels_r <= cfg_wdata;
    end
  end

endmodule

>>> design/tpfp_fifo.sv
// Short event queue between the front and back parts.
module tpfp_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tpfp_pkg::event_t wr_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output tpfp_pkg::event_t rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_CNT = (AW + 1)'(DEPTH);

  tpfp_pkg::event_t slots_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == DEPTH_CNT);
  assign valid   = (count_r != '0);
  assign rd_data = slots_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Advance pointers with wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + AW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + (AW + 1)'(1);
      2'b01:   count_nxt = count_r - (AW + 1)'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store slots
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= wr_data;
    end
  end

`include "assert_macros.svh"

  `CHK_PROP(a_fifo_count_bound, count_r <= DEPTH_CNT, "event queue count exceeds depth")
  `CHK_IMPL(a_fifo_no_overrun, push, !full, "event pushed into full queue")

endmodule

>>> design/tpfp_back.sv
// Back part: time products and serialization of results into the output register.
module tpfp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             ev_valid,
  input  tpfp_pkg::event_t ev_data,
  output logic             ev_pop,
  output logic             res_valid,
  input  logic             res_pop,
  output logic [1:0]       res_kind,
  output logic             res_last,
  output logic [31:0]      res_block_number,
  output logic             res_busy_first,
  output logic [31:0]      res_count_first,
  output logic [23:0]      res_scale_first,
  output logic             res_busy_second,
  output logic [31:0]      res_count_second,
  output logic [23:0]      res_scale_second,
  output logic [1:0]       res_changed_plate,
  output logic             res_changed_busy,
  output logic [55:0]      res_changed_time
);

  // Bit positions of the pending-result mask
  localparam int P_ERR  = 3;
  localparam int P_BLK  = 2;
  localparam int P_CH0  = 1;
  localparam int P_CH1  = 0;

  tpfp_pkg::event_t ent_r;
  logic [3:0]       pending_r, pending_nxt;
  logic [1:0][55:0] time_r;
  logic [1:0][55:0] prod;

  logic [3:0] sel, rest;
  logic       ent_valid, emit, load;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  kind_r;
  logic        last_r;
  logic [31:0] block_number_r;
  logic        busy_first_r, busy_second_r;
  logic [31:0] count_first_r, count_second_r;
  logic [23:0] scale_first_r, scale_second_r;
  logic [1:0]  changed_plate_r;
  logic        changed_busy_r;
  logic [55:0] changed_time_r;

  assign ent_valid = |pending_r;
  assign emit      = ent_valid && (!out_valid_r || res_pop);

  // Pick the pending result of the entry with the highest priority: error, block, first, second
  always_comb begin
    sel = 4'b0000;
    if (pending_r[P_ERR]) begin
      sel[P_ERR] = 1'b1;
    end else if (pending_r[P_BLK]) begin
      sel[P_BLK] = 1'b1;
    end else if (pending_r[P_CH0]) begin
      sel[P_CH0] = 1'b1;
    end else if (pending_r[P_CH1]) begin
      sel[P_CH1] = 1'b1;
    end
    rest = pending_r & ~sel;
  end

  assign load   = ev_valid && (!ent_valid || (emit && rest == 4'b0000));
  assign ev_pop = load;

  // Multiply counter by the scale latched with it
  assign prod[0] = 56'(ev_data.count[0]) * 56'(ev_data.time_scale[0]);
  assign prod[1] = 56'(ev_data.count[1]) * 56'(ev_data.time_scale[1]);

  always_comb begin
    pending_nxt = pending_r;
    if (load) begin
      pending_nxt = ev_data.is_err ? 4'b1000 : {1'b0, 1'b1, ev_data.changed[0],
                                                ev_data.changed[1]};
    end else if (emit) begin
      pending_nxt = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 4'b0000;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  // Hold the entry being serialized
  always_ff @(posedge clk) begin
    if (load) begin
      ent_r  <= ev_data;
      time_r <= prod;
    end
  end

  // Load the output register
  assign out_valid_nxt = emit ? 1'b1 : (res_pop ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r          <= tpfp_pkg::KIND_ERROR;
      last_r          <= (rest == 4'b0000);
      block_number_r  <= 32'd0;
      busy_first_r    <= 1'b0;
      count_first_r   <= 32'd0;
      scale_first_r   <= 24'd0;
      busy_second_r   <= 1'b0;
      count_second_r  <= 32'd0;
      scale_second_r  <= 24'd0;
      changed_plate_r <= tpfp_pkg::PLATE_NONE;
      changed_busy_r  <= 1'b0;
      changed_time_r  <= 56'd0;
      if (sel[P_BLK]) begin
        kind_r         <= tpfp_pkg::KIND_BLOCK;
        block_number_r <= ent_r.block_number;
        busy_first_r   <= ent_r.busy_old[0];
        count_first_r  <= ent_r.count[0];
        scale_first_r  <= ent_r.scale[0];
        busy_second_r  <= ent_r.busy_old[1];
        count_second_r <= ent_r.count[1];
        scale_second_r <= ent_r.scale[1];
      end else if (sel[P_CH0]) begin
        kind_r          <= tpfp_pkg::KIND_CHANGE;
        changed_plate_r <= tpfp_pkg::PLATE_FIRST;
        changed_busy_r  <= ent_r.busy_new[0];
        changed_time_r  <= time_r[0];
      end else if (sel[P_CH1]) begin
        kind_r          <= tpfp_pkg::KIND_CHANGE;
        changed_plate_r <= tpfp_pkg::PLATE_SECOND;
        changed_busy_r  <= ent_r.busy_new[1];
        changed_time_r  <= time_r[1];
      end
    end
  end

  assign res_valid         = out_valid_r;
  assign res_kind          = kind_r;
  assign res_last          = last_r;
  assign res_block_number  = block_number_r;
  assign res_busy_first    = busy_first_r;
  assign res_count_first   = count_first_r;
  assign res_scale_first   = scale_first_r;
  assign res_busy_second   = busy_second_r;
  assign res_count_second  = count_second_r;
  assign res_scale_second  = scale_second_r;
  assign res_changed_plate = changed_plate_r;
  assign res_changed_busy  = changed_busy_r;
  assign res_changed_time  = changed_time_r;

`include "assert_macros.svh"

  `CHK_IMPL(a_back_err_alone, pending_r[P_ERR], pending_r == 4'b1000,
            "error entry carries other results")
  `CHK_PROP(a_back_pending_hold,
            ($past(rst_n) && !$past(emit) && !$past(load)) |-> $stable(pending_r),
            "pending results changed without emit or load")

endmodule

>>> design/two_plate_timer_frame_parser.sv
// Top level of the two-plate timer frame parser.
//
//   channel | ports                          | transaction when
//   --------+--------------------------------+------------------------
//   config  | cfg_we, cfg_wdata              | cfg_we high
//   input   | in_push, in_full, in_data_byte | in_push && !in_full
//   result  | out_pop, out_empty, out_*      | out_pop && !out_empty
//
// One byte is taken per cycle while in_full is low; the front part classifies it
// in that cycle. Packet ends and errors become events in a QUEUE_DEPTH-entry
// queue; the back part drains one result per cycle (1 to 3 per event) into the
// output register when free or popped. in_full is high while the event queue is full.
// Reset clears all parser state and sets the channel count to four.
module two_plate_timer_frame_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_kind,
  output logic        out_last,
  output logic [31:0] out_block_number,
  output logic        out_busy_first,
  output logic [31:0] out_count_first,
  output logic [23:0] out_scale_first,
  output logic        out_busy_second,
  output logic [31:0] out_count_second,
  output logic [23:0] out_scale_second,
  output logic [1:0]  out_changed_plate,
  output logic        out_changed_busy,
  output logic [55:0] out_changed_time
);

  logic             accept;
  logic             ev_push, ev_pop, ev_valid, q_full, res_valid;
  tpfp_pkg::event_t ev_in, ev_out;

  assign in_full   = q_full;
  assign accept    = in_push && !q_full;
  assign out_empty = !res_valid;

  tpfp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .data_byte (in_data_byte),
    .ev_push   (ev_push),
    .ev_data   (ev_in)
  );

  tpfp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (ev_push),
    .wr_data (ev_in),
    .full    (q_full),
    .pop     (ev_pop),
    .valid   (ev_valid),
    .rd_data (ev_out)
  );

  tpfp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .ev_valid          (ev_valid),
    .ev_data           (ev_out),
    .ev_pop            (ev_pop),
    .res_valid         (res_valid),
    .res_pop           (out_pop),
    .res_kind          (out_kind),
    .res_last          (out_last),
    .res_block_number  (out_block_number),
    .res_busy_first    (out_busy_first),
    .res_count_first   (out_count_first),
    .res_scale_first   (out_scale_first),
    .res_busy_second   (out_busy_second),
    .res_count_second  (out_count_second),
    .res_scale_second  (out_scale_second),
    .res_changed_plate (out_changed_plate),
    .res_changed_busy  (out_changed_busy),
    .res_changed_time  (out_changed_time)
  );

endmodule
